FILE: rtl/mlr3_pkg.sv
// Package for the masked 3D Laplace relaxation unit: widths, codes, request and response types.
package mlr3_pkg;

  localparam int DIM_MAX     = 32;
  localparam int SAMPLE_BITS = 20;
  localparam int CW          = $clog2(DIM_MAX);      // coordinate width
  localparam int DIM_W       = $clog2(DIM_MAX + 1);  // size register width
  localparam int AW          = 3 * CW;               // voxel address width
  localparam int DEPTH       = 1 << AW;
  localparam int NW          = AW + 1;               // voxel count width
  localparam int SXY_W       = 2 * DIM_W;
  localparam int IDX_W       = 15;
  localparam int THR_W       = 15;
  localparam int SWEEP_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int QW          = SAMPLE_BITS + 3;      // neighbour sum / dividend width
  localparam int DW          = SAMPLE_BITS + 1;      // change magnitude width
  localparam int DCNT_W      = $clog2(QW);

  localparam logic signed [SAMPLE_BITS-1:0] ONE_Q = SAMPLE_BITS'(65536);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEPS = 3'd6;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SOLVE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP1, ST_PREP2, ST_LOAD, ST_RD_ISSUE, ST_RD_DATA,
    ST_CL_RD, ST_CL_WR, ST_SW_OWN, ST_SW_CHK, ST_NB_RD, ST_NB_ACC,
    ST_DIV_SET, ST_DIV, ST_DIV_END, ST_FIN, ST_MARK, ST_ADV, ST_RESP
  } state_t;

  typedef struct packed {
    req_type_t                     req_type;
    logic [IDX_W-1:0]              voxel_index;
    logic signed [SAMPLE_BITS-1:0] voxel_value;
  } vox_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] read_value;
    logic [SWEEP_W-1:0]            sweeps_done;
    logic                          converged;
    logic                          status;
  } vox_rsp_t;

  // size 0 acts as 1, above DIM_MAX as DIM_MAX
  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(DIM_MAX)) r = DIM_W'(DIM_MAX);
    return r;
  endfunction

endpackage

FILE: rtl/masked_laplace_relaxation_3d_unit.sv
// Masked six-neighbour Jacobi relaxation of a 3D volume held in on-chip memories.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------
//  request   | start / busy         | req  (vox_req_t)
//  response  | done (one cycle)     | rsp  (vox_rsp_t)
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A solve runs a clamp pass over every voxel and then the sweeps. In a sweep an
// inactive voxel is copied across; a pending voxel reads its six neighbours
// through the single read port of each memory and divides their sum in the
// bit-serial divider, which is skipped when no neighbour qualifies, and then
// marks neighbours when its change is large.
// Reset sets control and configuration to defaults only; memories hold no reset value.
// The receiver cannot stall; busy stays high until the response cycle ends.
module masked_laplace_relaxation_3d_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  mlr3_pkg::vox_req_t                  req,
  output logic                                done,
  output mlr3_pkg::vox_rsp_t                  rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mlr3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlr3_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mlr3_pkg::*;

  localparam logic [2:0] K_LAST = 3'd5;
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(QW - 1);

  state_t state, state_next;

  // configuration
  logic signed [SAMPLE_BITS-1:0] low_bound, high_bound;
  logic [THR_W-1:0]   stop_threshold;
  logic [DIM_W-1:0]   size_x, size_y, size_z;
  logic [SWEEP_W-1:0] max_sweeps;

  // request and geometry
  vox_req_t           req_r;
  logic [DIM_W-1:0]   sx, sy, sz;
  logic [SXY_W-1:0]   sxy;
  logic [NW-1:0]      n;
  logic [SXY_W+DIM_W-1:0] n_prod;
  logic               in_range;

  // walk state
  logic [AW-1:0]      i;
  logic [CW-1:0]      x, y, z;
  logic [2:0]         k;
  logic               cur_bank;
  logic [SWEEP_W-1:0] sweep_count;
  logic               converged_flag;
  logic [DW-1:0]      mx;

  // per-voxel datapath
  logic signed [SAMPLE_BITS-1:0] own_c, nv;
  logic signed [QW-1:0] sum;
  logic [2:0]         cnt;
  logic [5:0]         strict;
  logic [QW-1:0]      dq;
  logic [2:0]         rem;
  logic [DCNT_W-1:0]  dcnt;
  logic               neg;

  // response payload
  logic signed [SAMPLE_BITS-1:0] rsp_value;
  logic               rsp_status;

  // memories
  logic signed [SAMPLE_BITS-1:0] in_mem [0:DEPTH-1];
  logic signed [SAMPLE_BITS-1:0] lv_mem [0:2*DEPTH-1];
  logic                          pend_mem [0:DEPTH-1];
  logic signed [SAMPLE_BITS-1:0] in_q, lv_q;
  logic                          pend_q;

  logic                 in_we;
  logic [AW-1:0]        in_waddr, in_raddr;
  logic signed [SAMPLE_BITS-1:0] in_wdata;
  logic                 lv_we;
  logic [AW:0]          lv_waddr, lv_raddr;
  logic signed [SAMPLE_BITS-1:0] lv_wdata;
  logic                 pend_we, pend_wdata;
  logic [AW-1:0]        pend_waddr, pend_raddr;

  // combinational helpers
  logic               nb_ok;
  logic [AW-1:0]      nb_addr;
  logic [DIM_W-1:0]   x_inc, y_inc, z_inc;
  logic [CW-1:0]      x_adv, y_adv, z_adv;
  logic               last_vox;
  logic               own_active;
  logic signed [SAMPLE_BITS-1:0] clamped;
  logic [QW-1:0]      abs_sum;
  logic [3:0]         rem_sh;
  logic               div_ge;
  logic signed [DW-1:0] diff;
  logic [DW-1:0]      d;
  logic [DW+3:0]      d10;
  logic               big;
  logic [SWEEP_W-1:0] cap;
  logic               sweep_more;
  logic               nb_in_band, nb_strict;

  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_RESP);
  assign cfg_ready = 1'b1;

  assign rsp.read_value  = rsp_value;
  assign rsp.sweeps_done = sweep_count;
  assign rsp.converged   = converged_flag;
  assign rsp.status      = rsp_status;

  assign n_prod   = sxy * sz;
  assign in_range = ({1'b0, req_r.voxel_index[AW-1:0]} < n);
  assign last_vox = ({1'b0, i} == n - NW'(1));

  // coordinate stepping in raster order
  assign x_inc = {1'b0, x} + DIM_W'(1);
  assign y_inc = {1'b0, y} + DIM_W'(1);
  assign z_inc = {1'b0, z} + DIM_W'(1);
  always_comb begin
    x_adv = x_inc[CW-1:0];
    y_adv = y;
    z_adv = z;
    if (x_inc == sx) begin
      x_adv = '0;
      y_adv = y_inc[CW-1:0];
      if (y_inc == sy) begin
        y_adv = '0;
        z_adv = z_inc[CW-1:0];
      end
    end
  end

  // face neighbour k of the current voxel
  always_comb begin
    nb_ok   = 1'b0;
    nb_addr = i;
    case (k)
      3'd0: begin
        nb_ok   = (x != '0);
        nb_addr = i - AW'(1);
      end
      3'd1: begin
        nb_ok   = (x_inc < sx);
        nb_addr = i + AW'(1);
      end
      3'd2: begin
        nb_ok   = (y != '0);
        nb_addr = i - AW'(sx);
      end
      3'd3: begin
        nb_ok   = (y_inc < sy);
        nb_addr = i + AW'(sx);
      end
      3'd4: begin
        nb_ok   = (z != '0);
        nb_addr = i - AW'(sxy);
      end
      3'd5: begin
        nb_ok   = (z_inc < sz);
        nb_addr = i + AW'(sxy);
      end
      default: begin
        nb_ok   = 1'b0;
        nb_addr = i;
      end
    endcase
  end

  assign nb_in_band = nb_ok && (in_q >= low_bound) && (in_q <= high_bound);
  assign nb_strict  = nb_ok && (in_q > low_bound) && (in_q < high_bound);
  assign own_active = (lv_q > low_bound) && (lv_q < high_bound) && pend_q;
  assign clamped    = (in_q < low_bound) ? '0 : ((in_q > high_bound) ? ONE_Q : in_q);

  // divider step and change measure
  assign abs_sum = sum[QW-1] ? QW'(-sum) : QW'(sum);
  assign rem_sh  = {rem, dq[QW-1]};
  assign div_ge  = (rem_sh >= {1'b0, cnt});
  assign diff    = {own_c[SAMPLE_BITS-1], own_c} - {nv[SAMPLE_BITS-1], nv};
  assign d       = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign d10     = {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
  assign big     = (d10 > (DW+4)'(stop_threshold));
  assign cap     = (max_sweeps == '0) ? SWEEP_W'(1) : max_sweeps;
  assign sweep_more = (mx > DW'(stop_threshold)) &&
                      (({1'b0, sweep_count} + (SWEEP_W+1)'(1)) < {1'b0, cap});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = ST_PREP1;
      ST_PREP1:    state_next = ST_PREP2;
      ST_PREP2: begin
        case (req_r.req_type)
          REQ_LOAD:  state_next = ST_LOAD;
          REQ_READ:  state_next = ST_RD_ISSUE;
          REQ_SOLVE: state_next = ST_CL_RD;
          default:   state_next = ST_RESP;
        endcase
      end
      ST_LOAD:     state_next = ST_RESP;
      ST_RD_ISSUE: state_next = ST_RD_DATA;
      ST_RD_DATA:  state_next = ST_RESP;
      ST_CL_RD:    state_next = ST_CL_WR;
      ST_CL_WR:    state_next = last_vox ? ST_SW_OWN : ST_CL_RD;
      ST_SW_OWN:   state_next = ST_SW_CHK;
      ST_SW_CHK:   state_next = own_active ? ST_NB_RD : ST_ADV;
      ST_NB_RD:    state_next = ST_NB_ACC;
      ST_NB_ACC:   state_next = (k == K_LAST) ? ST_DIV_SET : ST_NB_RD;
      ST_DIV_SET:  state_next = (cnt == '0) ? ST_FIN : ST_DIV;
      ST_DIV:      state_next = (dcnt == DCNT_LAST) ? ST_DIV_END : ST_DIV;
      ST_DIV_END:  state_next = ST_FIN;
      ST_FIN:      state_next = big ? ST_MARK : ST_ADV;
      ST_MARK:     state_next = (k == K_LAST) ? ST_ADV : ST_MARK;
      ST_ADV: begin
        if (!last_vox) state_next = ST_SW_OWN;
        else if (sweep_more) state_next = ST_SW_OWN;
        else state_next = ST_RESP;
      end
      ST_RESP:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    in_we      = 1'b0;
    in_waddr   = req_r.voxel_index[AW-1:0];
    in_wdata   = req_r.voxel_value;
    in_raddr   = i;
    lv_we      = 1'b0;
    lv_waddr   = {~cur_bank, i};
    lv_wdata   = lv_q;
    lv_raddr   = {cur_bank, i};
    pend_we    = 1'b0;
    pend_waddr = i;
    pend_wdata = 1'b0;
    pend_raddr = i;
    case (state)
      ST_LOAD:     in_we = in_range;
      ST_RD_ISSUE: lv_raddr = {cur_bank, req_r.voxel_index[AW-1:0]};
      ST_CL_WR: begin
        lv_we      = 1'b1;
        lv_waddr   = {1'b0, i};
        lv_wdata   = clamped;
        pend_we    = 1'b1;
        pend_wdata = (in_q > low_bound) && (in_q < high_bound);
      end
      ST_SW_CHK:   lv_we = !own_active;
      ST_NB_RD: begin
        in_raddr = nb_addr;
        lv_raddr = {cur_bank, nb_addr};
      end
      ST_FIN: begin
        lv_we    = 1'b1;
        lv_wdata = nv;
        pend_we  = 1'b1;
      end
      ST_MARK: begin
        pend_we    = strict[k];
        pend_waddr = nb_addr;
        pend_wdata = 1'b1;
      end
      default: begin
        in_we = 1'b0;
      end
    endcase
  end

  // memories, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_we) in_mem[in_waddr] <= in_wdata;
    in_q <= in_mem[in_raddr];
  end

  always_ff @(posedge clk) begin
    if (lv_we) lv_mem[lv_waddr] <= lv_wdata;
    lv_q <= lv_mem[lv_raddr];
  end

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_waddr] <= pend_wdata;
    pend_q <= pend_mem[pend_raddr];
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      low_bound      <= '0;
      high_bound     <= ONE_Q;
      stop_threshold <= THR_W'(66);
      size_x         <= DIM_W'(DIM_MAX);
      size_y         <= DIM_W'(DIM_MAX);
      size_z         <= DIM_W'(DIM_MAX);
      max_sweeps     <= '1;
      sweep_count    <= '0;
      converged_flag <= 1'b0;
      cur_bank       <= 1'b0;
      k              <= '0;
      cnt            <= '0;
    end else begin
      state <= state_next;

      // configuration writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LOW:    low_bound      <= cfg_data[SAMPLE_BITS-1:0];
          CFG_HIGH:   high_bound     <= cfg_data[SAMPLE_BITS-1:0];
          CFG_THR:    stop_threshold <= cfg_data[THR_W-1:0];
          CFG_SIZE_X: size_x         <= cfg_data[DIM_W-1:0];
          CFG_SIZE_Y: size_y         <= cfg_data[DIM_W-1:0];
          CFG_SIZE_Z: size_z         <= cfg_data[DIM_W-1:0];
          CFG_SWEEPS: max_sweeps     <= cfg_data[SWEEP_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: if (start) req_r <= req;
        ST_PREP1: begin
          sx  <= dim_clamp(size_x);
          sy  <= dim_clamp(size_y);
          sz  <= dim_clamp(size_z);
          sxy <= SXY_W'(dim_clamp(size_x)) * SXY_W'(dim_clamp(size_y));
        end
        ST_PREP2: begin
          n          <= n_prod[NW-1:0];
          i          <= '0;
          x          <= '0;
          y          <= '0;
          z          <= '0;
          rsp_value  <= '0;
          rsp_status <= 1'b0;
        end
        ST_LOAD:    rsp_status <= !in_range;
        ST_RD_DATA: begin
          rsp_value  <= in_range ? lv_q : '0;
          rsp_status <= !in_range;
        end
        ST_CL_WR: begin
          if (last_vox) begin
            i           <= '0;
            x           <= '0;
            y           <= '0;
            z           <= '0;
            mx          <= '0;
            sweep_count <= '0;
            cur_bank    <= 1'b0;
          end else begin
            i <= i + AW'(1);
            x <= x_adv;
            y <= y_adv;
            z <= z_adv;
          end
        end
        ST_SW_CHK: begin
          own_c <= lv_q;
          sum   <= '0;
          cnt   <= '0;
          k     <= '0;
        end
        ST_NB_ACC: begin
          if (nb_in_band) begin
            sum <= sum + {{3{lv_q[SAMPLE_BITS-1]}}, lv_q};
            cnt <= cnt + 3'd1;
          end
          strict[k] <= nb_strict;
          if (k != K_LAST) k <= k + 3'd1;
        end
        ST_DIV_SET: begin
          nv   <= own_c;
          dq   <= abs_sum + QW'(cnt >> 1);
          neg  <= sum[QW-1];
          rem  <= '0;
          dcnt <= '0;
        end
        ST_DIV: begin
          rem  <= div_ge ? 3'(rem_sh - {1'b0, cnt}) : rem_sh[2:0];
          dq   <= {dq[QW-2:0], div_ge};
          dcnt <= dcnt + DCNT_W'(1);
        end
        ST_DIV_END: nv <= neg ? -dq[SAMPLE_BITS-1:0] : dq[SAMPLE_BITS-1:0];
        ST_FIN: begin
          if (d > mx) mx <= d;
          k <= '0;
        end
        ST_MARK: if (k != K_LAST) k <= k + 3'd1;
        ST_ADV: begin
          if (last_vox) begin
            sweep_count <= sweep_count + SWEEP_W'(1);
            cur_bank    <= ~cur_bank;
            if (sweep_more) begin
              i  <= '0;
              x  <= '0;
              y  <= '0;
              z  <= '0;
              mx <= '0;
            end else begin
              converged_flag <= (mx <= DW'(stop_threshold));
            end
          end else begin
            i <= i + AW'(1);
            x <= x_adv;
            y <= y_adv;
            z <= z_adv;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a response lasts exactly one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // an accepted request makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but unit not busy");

  // sweeps write the bank that is not being read
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (lv_we && (state == ST_SW_CHK || state == ST_FIN)) |-> (lv_waddr[AW] != cur_bank))
    else $error("sweep writes the bank it reads");

  // at most six qualifying neighbours
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd6)
    else $error("neighbour count out of range");
`endif

endmodule
